[hdl/sbph_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbph_pkg
// Types, codes and constants shared by the spectrum bar/peak-hold block.
// ----------------------------------------------------------------------------
package sbph_pkg;

    localparam int MAX_BANDS_DEF = 64;
    localparam int FFT_BINS_DEF  = 1024;
    localparam int BIN_START     = 50;
    localparam int BIN_END       = 1000;
    localparam int STEP_BASE     = 1024;
    localparam int STEP_DIV      = 5;
    localparam int HOLD_FRAMES   = 20;

    localparam int ENTRY_W  = 21;   // {hold[4:0], peak[7:0], bar[7:0]}
    localparam int DIV_N_W  = 18;
    localparam int DIV_D_W  = 11;

    typedef enum logic [1:0] {
        REQ_FRAME = 2'd0,
        REQ_BIN   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_BAND   = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] REG_BANDS  = 2'd0;
    localparam logic [1:0] REG_LEVELS = 2'd1;
    localparam logic [1:0] REG_PEAKS  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP,
        S_STEP,
        S_SQRT,
        S_MUL,
        S_ACC,
        S_MEAN,
        S_UPD,
        S_RDD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

endpackage

[hdl/sbph_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbph_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module sbph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

[hdl/sbph_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbph_sqrt
// Integer square root of a 32-bit word, one root bit per cycle.
// ----------------------------------------------------------------------------
module sbph_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_radicand,
    output logic        o_done,
    output logic [15:0] o_root
);

    logic [31:0] r_x;
    logic [17:0] r_rem;
    logic [15:0] r_root;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [19:0] w_rem_sh;
    logic [19:0] w_trial;
    logic        w_ge;

    assign w_rem_sh = {r_rem, r_x[31:30]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_x    <= {r_x[29:0], 2'b00};
                r_rem  <= w_ge ? 18'(w_rem_sh - w_trial) : w_rem_sh[17:0];
                r_root <= {r_root[14:0], w_ge};
                r_cnt  <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[hdl/sbph_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbph_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbph_div
    import sbph_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_den;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DIV_D_W:0]   w_rem_sh;
    logic               w_ge;

    assign w_rem_sh = {r_rem, r_quo[DIV_N_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? DIV_D_W'(w_rem_sh - {1'b0, r_den})
                              : w_rem_sh[DIV_D_W-1:0];
                r_quo <= {r_quo[DIV_N_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hdl/spectrum_bar_peak_hold.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_bar_peak_hold
// Frame start: a band sweep through the band RAM (skipped when no bands or
//   levels are set), plus the band-width divide when a spectrum follows.
// Power bin: no work outside used bands, sqrt + multiply inside, plus a
//   mean divide and RAM read-modify-write when the bin closes a band.
// Read: a band RAM read. Clear: all valid bits drop. One item at a time; a
//   finished beat waits in the output register while the next item is accepted.
// Reset: synchronous; per-entry valid bits make every band read as zero.
// ----------------------------------------------------------------------------
module spectrum_bar_peak_hold
    import sbph_pkg::*;
#(
    parameter int MAX_BANDS = MAX_BANDS_DEF,
    parameter int FFT_BINS  = FFT_BINS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // paused, has_data, power[31:0], band_select[5:0]
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    // stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // animation_done, band_index[5:0], bar_level[7:0],
                                     // peak_level[7:0], zero pad
    output logic [1:0]  o_m_tuser,   // kind[1:0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int NB_W   = $clog2(MAX_BANDS + 1);
    localparam int BC_W   = $clog2(FFT_BINS + 1);
    localparam int SPAN_W = NB_W + 8;

    // ---------------- configuration ----------------
    logic [6:0] r_num_bands;
    logic [8:0] r_num_levels;
    logic       r_peaks_en;
    logic       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_BANDS:  prdata = {25'd0, r_num_bands};
            REG_LEVELS: prdata = {23'd0, r_num_levels};
            REG_PEAKS:  prdata = {31'd0, r_peaks_en};
            default:    prdata = '0;
        endcase
    end

    logic [NB_W-1:0] w_nb;
    logic [8:0]      w_nl;
    logic [8:0]      w_nlm1;
    logic [10:0]     w_nl5;

    assign w_nb   = (32'(r_num_bands) > MAX_BANDS) ? NB_W'(MAX_BANDS) : NB_W'(r_num_bands);
    assign w_nl   = (r_num_levels > 9'd256) ? 9'd256 : r_num_levels;
    assign w_nlm1 = w_nl - 9'd1;
    assign w_nl5  = 11'(w_nl) * 11'(STEP_DIV);

    // ---------------- input fields ----------------
    t_req        w_req;
    logic        w_paused;
    logic        w_has;
    logic [31:0] w_power;
    logic [5:0]  w_sel;
    logic        w_acc;

    assign w_req    = t_req'(i_s_tuser);
    assign w_paused = i_s_tdata[0];
    assign w_has    = i_s_tdata[1];
    assign w_power  = i_s_tdata[33:2];
    assign w_sel    = i_s_tdata[39:34];

    // ---------------- state ----------------
    t_state r_state, n_state;

    logic               r_vld [MAX_BANDS];
    logic               r_rd_vld;
    logic [BC_W-1:0]    r_bin_cnt;
    logic [NB_W-1:0]    r_band_cnt;
    logic [7:0]         r_bib;
    logic [17:0]        r_sum;
    logic [7:0]         r_step;
    logic               r_active;

    logic               r_paused;
    logic               r_has;
    logic               r_stop;
    logic [NB_W-1:0]    r_idx;
    logic [IDX_W-1:0]   r_widx;
    logic               r_pend;
    logic [5:0]         r_sel;
    logic               r_sel_oob;
    logic [26:0]        r_prod;

    logic [1:0]         r_res_kind;
    logic               r_res_done;
    logic [5:0]         r_res_idx;
    logic [7:0]         r_res_bar;
    logic [7:0]         r_res_peak;

    logic               r_ov;
    logic [1:0]         r_okind;
    logic [23:0]        r_odata;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid & o_s_tready;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_okind;

    // ---------------- units ----------------
    logic               w_sq_start;
    logic               w_sq_done;
    logic [15:0]        w_root;
    t_div_req           w_div_req;
    logic               w_div_done;
    logic [DIV_N_W-1:0] w_quo;

    logic               w_re;
    logic [IDX_W-1:0]   w_raddr;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [ENTRY_W-1:0] w_rdata;

    sbph_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (w_power),
        .o_done     (w_sq_done),
        .o_root     (w_root)
    );

    sbph_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    sbph_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BANDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- datapath terms ----------------
    logic [ENTRY_W-1:0] w_ent;
    logic [7:0]         w_bar, w_peak;
    logic [4:0]         w_hold;
    logic [SPAN_W-1:0]  w_span;
    logic               w_in_range;
    logic               w_sw_rd;
    logic [10:0]        w_v;
    logic [17:0]        w_sum_new;
    logic [7:0]         w_bib_new;
    logic               w_band_full;
    logic [7:0]         w_mean;

    // sweep update
    logic [7:0]         w_f_bar, w_f_peak;
    logic [4:0]         w_f_hold;
    logic               w_f_moved;
    // band update
    logic [7:0]         w_u_bar, w_u_peak;
    logic [4:0]         w_u_hold;

    assign w_ent  = r_rd_vld ? w_rdata : '0;
    assign w_bar  = w_ent[7:0];
    assign w_peak = w_ent[15:8];
    assign w_hold = w_ent[20:16];

    assign w_span     = (SPAN_W'(r_band_cnt) + SPAN_W'(1)) * SPAN_W'(r_step);
    assign w_in_range = (32'(r_bin_cnt) >= BIN_START) && (r_band_cnt < w_nb)
                        && (w_nl != 9'd0) && (32'(w_span) + BIN_START <= BIN_END);
    assign w_sw_rd    = (r_idx < w_nb);

    assign w_v         = r_prod[26:16];
    assign w_sum_new   = r_sum + 18'(w_v);
    assign w_bib_new   = r_bib + 8'd1;
    assign w_band_full = (w_bib_new >= r_step);
    assign w_mean      = (w_quo > 18'(w_nlm1)) ? w_nlm1[7:0] : w_quo[7:0];

    always_comb begin
        w_f_bar   = w_bar;
        w_f_peak  = w_peak;
        w_f_hold  = w_hold;
        w_f_moved = 1'b0;
        if (!r_paused && w_bar != 8'd0) begin
            w_f_bar   = w_bar - 8'd1;
            w_f_moved = 1'b1;
        end
        if (r_peaks_en) begin
            if (w_hold != 5'd0) begin
                w_f_hold = w_hold - 5'd1;
            end
            if (w_peak > w_f_bar) begin
                w_f_moved = 1'b1;
                if (w_f_hold == 5'd0) begin
                    w_f_peak = w_peak - 8'd1;
                end
            end
        end
    end

    always_comb begin
        w_u_bar  = (w_mean > w_bar) ? w_mean : w_bar;
        w_u_peak = w_peak;
        w_u_hold = w_hold;
        if (r_peaks_en && w_mean > w_peak) begin
            w_u_peak = w_mean;
            w_u_hold = 5'(HOLD_FRAMES);
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (w_req)
                        REQ_FRAME: begin
                            if (w_nb == '0 || w_nl == 9'd0) n_state = S_EMIT;
                            else                             n_state = S_SWEEP;
                        end
                        REQ_BIN:   n_state = (r_active && w_in_range) ? S_SQRT : S_IDLE;
                        REQ_READ:  n_state = S_RDD;
                        REQ_CLEAR: n_state = S_IDLE;
                    endcase
                end
            end
            S_SWEEP: begin
                if (!w_sw_rd && !r_pend) n_state = r_has ? S_STEP : S_EMIT;
            end
            S_STEP:  if (w_div_done) n_state = S_EMIT;
            S_SQRT:  if (w_sq_done) n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = w_band_full ? S_MEAN : S_IDLE;
            S_MEAN:  if (w_div_done) n_state = S_UPD;
            S_UPD:   n_state = S_EMIT;
            S_RDD:   n_state = S_EMIT;
            S_EMIT:  if (!r_ov || i_m_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        w_sq_start         = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = 18'(w_sum_new);
        w_div_req.divisor  = DIV_D_W'(r_step);
        w_re               = 1'b0;
        w_raddr            = IDX_W'(r_idx);
        w_we               = 1'b0;
        w_waddr            = r_widx;
        w_wdata            = {w_f_hold, w_f_peak, w_f_bar};
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && w_req == REQ_BIN && r_active && w_in_range) begin
                    w_sq_start = 1'b1;
                end
                if (w_acc && w_req == REQ_READ) begin
                    w_re    = 1'b1;
                    w_raddr = IDX_W'(w_sel);
                end
            end
            S_SWEEP: begin
                w_re = w_sw_rd;
                w_we = r_pend;
                if (!w_sw_rd && !r_pend && r_has) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = 18'(STEP_BASE);
                    w_div_req.divisor  = DIV_D_W'(w_nb) * DIV_D_W'(STEP_DIV);
                end
            end
            S_ACC:  w_div_req.start = w_band_full;
            S_MEAN: begin
                w_re    = w_div_done;
                w_raddr = IDX_W'(r_band_cnt);
            end
            S_UPD: begin
                w_we    = 1'b1;
                w_waddr = IDX_W'(r_band_cnt);
                w_wdata = {w_u_hold, w_u_peak, w_u_bar};
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_num_bands  <= 7'd64;
            r_num_levels <= 9'd16;
            r_peaks_en   <= 1'b0;
            for (int i = 0; i < MAX_BANDS; i++) r_vld[i] <= 1'b0;
            r_bin_cnt    <= '0;
            r_band_cnt   <= '0;
            r_bib        <= '0;
            r_sum        <= '0;
            r_step       <= 8'd1;
            r_active     <= 1'b0;
            r_pend       <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_wr) begin
                unique case (paddr[3:2])
                    REG_BANDS: begin
                        r_num_bands <= pwdata[6:0];
                        // drop bands beyond the new count
                        for (int i = 0; i < MAX_BANDS; i++) begin
                            if (i >= 32'(pwdata[6:0])) r_vld[i] <= 1'b0;
                        end
                    end
                    REG_LEVELS: r_num_levels <= pwdata[8:0];
                    REG_PEAKS:  r_peaks_en   <= pwdata[0];
                    default: ;
                endcase
            end

            if (w_re) r_rd_vld <= r_vld[w_raddr];
            if (w_we) r_vld[w_waddr] <= 1'b1;

            // the emit state reloads the output register itself
            if (r_ov && i_m_tready && r_state != S_EMIT) r_ov <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_paused   <= w_paused;
                        r_has      <= w_has;
                        r_stop     <= 1'b1;
                        r_idx      <= '0;
                        r_pend     <= 1'b0;
                        r_sel      <= w_sel;
                        r_sel_oob  <= (32'(w_sel) >= MAX_BANDS);
                        r_res_kind <= KIND_STATUS;
                        r_res_done <= ~w_has;
                        r_res_idx  <= '0;
                        r_res_bar  <= '0;
                        r_res_peak <= '0;
                        priority case (w_req)
                            REQ_BIN: begin
                                if (r_active) begin
                                    r_bin_cnt <= r_bin_cnt + 1'b1;
                                    if (32'(r_bin_cnt) + 1 >= FFT_BINS) r_active <= 1'b0;
                                end
                            end
                            REQ_CLEAR: begin
                                for (int i = 0; i < MAX_BANDS; i++) r_vld[i] <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SWEEP: begin
                    r_pend <= w_sw_rd;
                    r_widx <= IDX_W'(r_idx);
                    if (w_sw_rd) r_idx <= r_idx + 1'b1;
                    if (r_pend && w_f_moved) r_stop <= 1'b0;
                    if (!w_sw_rd && !r_pend) r_res_done <= r_has ? 1'b0 : r_stop;
                end
                S_STEP: begin
                    if (w_div_done) begin
                        r_step     <= (w_quo == '0) ? 8'd1 : w_quo[7:0];
                        r_bin_cnt  <= '0;
                        r_band_cnt <= '0;
                        r_bib      <= '0;
                        r_sum      <= '0;
                        r_active   <= 1'b1;
                    end
                end
                S_MUL: r_prod <= 27'(w_root) * 27'(w_nl5);
                S_ACC: begin
                    if (w_band_full) begin
                        r_sum <= '0;
                        r_bib <= '0;
                    end else begin
                        r_sum <= w_sum_new;
                        r_bib <= w_bib_new;
                    end
                end
                S_UPD: begin
                    r_res_kind <= KIND_BAND;
                    r_res_done <= 1'b0;
                    r_res_idx  <= 6'(r_band_cnt);
                    r_res_bar  <= w_u_bar;
                    r_res_peak <= w_u_peak;
                    r_band_cnt <= r_band_cnt + 1'b1;
                end
                S_RDD: begin
                    r_res_kind <= KIND_READ;
                    r_res_done <= 1'b0;
                    r_res_idx  <= r_sel;
                    r_res_bar  <= r_sel_oob ? 8'd0 : w_bar;
                    r_res_peak <= r_sel_oob ? 8'd0 : w_peak;
                end
                S_EMIT: begin
                    if (!r_ov || i_m_tready) begin
                        r_ov    <= 1'b1;
                        r_okind <= r_res_kind;
                        r_odata <= {1'b0, r_res_peak, r_res_bar, r_res_idx, r_res_done};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
